[rtl/skht_pkg.sv]
// Package for the string key hash table: status codes, opcodes and hash seed.
// No dependencies.
package skht_pkg;
    localparam logic [2:0] ST_INSERTED  = 3'd0;
    localparam logic [2:0] ST_FOUND     = 3'd1;
    localparam logic [2:0] ST_NOT_FOUND = 3'd2;
    localparam logic [2:0] ST_FULL      = 3'd3;
    localparam logic [2:0] ST_TOO_LONG  = 3'd4;
    localparam logic [63:0] HASH_SEED   = 64'd5381;
    localparam logic [0:0] OP_INSERT    = 1'b0;
    localparam logic [0:0] OP_LOOKUP    = 1'b1;
endpackage

[rtl/string_key_hash_table_core.sv]
// String key hash table (djb2, quadratic probing), top level.
// Uses skht_pkg.
//
// Key bytes are taken one per cycle while hashing and no result is waiting. On
// the last byte of a key that fits and, for an insert, finds room in the table,
// the block stops taking items and runs a probe sequencer. The first slot visit,
// and each further visit of a lookup, starts with a fetch state that reads the
// slot's stored length and type, then a check state; an insert that meets an
// occupied slot moves on to the next probe from the check state. A lookup whose
// length matches compares stored key bytes one per cycle through the key memory
// read port. An insert writes the pending key into the free slot one byte per
// cycle. The result waits in an output register and holds off new items until
// it is taken; no clearing pass is needed (used bits are flip-flops).
module string_key_hash_table_core #(
    parameter int TABLE_SLOTS   = 64,
    parameter int MAX_KEY_BYTES = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [0:0] i_opcode,
    input  logic [7:0] i_key_byte,
    input  logic [0:0] i_last_byte,
    input  logic [2:0] i_var_type,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [2:0] o_status,
    output logic [5:0] o_slot_index,
    output logic [2:0] o_found_type
);
    import skht_pkg::*;

    localparam int SW = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
    localparam int KW = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;
    localparam int LW = $clog2(MAX_KEY_BYTES + 1);
    localparam int CW = $clog2(TABLE_SLOTS + 1);

    localparam logic [2:0] S_HASH  = 3'd0;
    localparam logic [2:0] S_PROBE = 3'd1;
    localparam logic [2:0] S_CMP   = 3'd2;
    localparam logic [2:0] S_WRITE = 3'd3;
    localparam logic [2:0] S_FETCH = 3'd4;

    logic [2:0]     r_state;
    logic [63:0]    r_hash;
    logic [63:0]    n_hash;
    logic [LW-1:0]  r_len;
    logic           r_ovf;
    logic [0:0]     r_op;
    logic [2:0]     r_vtype;
    logic [SW-1:0]  r_pos;
    logic [CW-1:0]  r_step;
    logic [CW-1:0]  r_count;
    logic [LW-1:0]  r_idx;
    logic [TABLE_SLOTS-1:0] r_used;
    logic [2:0]     r_status;
    logic [5:0]     r_slot;
    logic [2:0]     r_ftype;
    logic           r_ovalid;

    logic [7:0]     pend_mem [MAX_KEY_BYTES];
    logic [7:0]     key_mem  [TABLE_SLOTS*MAX_KEY_BYTES];
    logic [LW-1:0]  len_mem  [TABLE_SLOTS];
    logic [2:0]     type_mem [TABLE_SLOTS];
    logic [7:0]     r_pend_rd, r_key_rd;
    logic [LW-1:0]  r_len_rd;
    logic [2:0]     r_type_rd;

    localparam int AW = $clog2(TABLE_SLOTS*MAX_KEY_BYTES);
    logic [AW-1:0] key_addr;
    logic [KW-1:0] idx_k;
    logic          in_fire;
    logic [CW+CW-1:0] sq;

    assign idx_k    = r_idx[KW-1:0];
    assign key_addr = AW'(r_pos) * AW'(MAX_KEY_BYTES) + AW'(idx_k);
    assign in_fire  = i_valid && o_ready;
    assign o_ready  = (r_state == S_HASH) && !r_ovalid;
    assign sq       = (CW+CW)'(r_step) * (CW+CW)'(r_step);
    assign n_hash   = (r_hash << 5) + r_hash + 64'(i_key_byte);

    // pending key, key, length and type stores, one write and one read port each
    // r_idx drives the byte read address; reads are registered
    always_ff @(posedge i_clk) begin
        if (in_fire && r_len < LW'(MAX_KEY_BYTES))
            pend_mem[r_len[KW-1:0]] <= i_key_byte;
        r_pend_rd <= pend_mem[idx_k];
        if (r_state == S_WRITE && r_idx != '0)
            key_mem[AW'(r_pos) * AW'(MAX_KEY_BYTES) + AW'(r_idx - 1'b1)] <= r_pend_rd;
        r_key_rd <= key_mem[key_addr];
        if (r_state == S_WRITE && r_idx == r_len) begin
            len_mem[r_pos]  <= r_len;
            type_mem[r_pos] <= r_vtype;
        end
        r_len_rd  <= len_mem[r_pos];
        r_type_rd <= type_mem[r_pos];
    end

    task automatic finish(input logic [2:0] st, input logic [5:0] sl, input logic [2:0] ft);
        r_status <= st;
        r_slot   <= sl;
        r_ftype  <= ft;
        r_ovalid <= 1'b1;
        r_state  <= S_HASH;
        r_hash   <= HASH_SEED;
        r_len    <= '0;
        r_ovf    <= 1'b0;
    endtask

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_HASH;
            r_hash   <= HASH_SEED;
            r_len    <= '0;
            r_ovf    <= 1'b0;
            r_used   <= '0;
            r_count  <= '0;
            r_ovalid <= 1'b0;
            r_idx    <= '0;
            r_step   <= '0;
        end else begin
            if (r_ovalid && i_ready) r_ovalid <= 1'b0;
            case (r_state)
                S_HASH: if (in_fire) begin
                    r_op    <= i_opcode;
                    r_vtype <= i_var_type;
                    r_pos   <= SW'(n_hash);
                    r_step  <= CW'(1);
                    r_idx   <= '0;
                    if (i_last_byte == 1'b1 && (r_ovf || r_len == LW'(MAX_KEY_BYTES)))
                        finish(ST_TOO_LONG, 6'd0, 3'd0);
                    else if (i_last_byte == 1'b1 && i_opcode == OP_INSERT &&
                             r_count >= CW'(TABLE_SLOTS))
                        finish(ST_FULL, 6'd0, 3'd0);
                    else begin
                        r_hash <= n_hash;
                        if (r_len < LW'(MAX_KEY_BYTES)) r_len <= r_len + 1'b1;
                        else r_ovf <= 1'b1;
                        if (i_last_byte == 1'b1) r_state <= S_FETCH;
                    end
                end
                S_FETCH: r_state <= S_PROBE;
                S_PROBE: begin
                    if (r_step > CW'(TABLE_SLOTS)) begin
                        finish((r_op == OP_INSERT) ? ST_FULL : ST_NOT_FOUND, 6'd0, 3'd0);
                    end else if (r_op == OP_INSERT) begin
                        if (!r_used[r_pos]) r_state <= S_WRITE;
                        else begin
                            r_pos  <= r_pos + SW'(sq);
                            r_step <= r_step + 1'b1;
                        end
                    end else begin
                        if (!r_used[r_pos]) finish(ST_NOT_FOUND, 6'd0, 3'd0);
                        else if (r_len_rd == r_len) begin
                            r_state <= S_CMP;
                            r_idx   <= LW'(1);
                        end else begin
                            r_pos   <= r_pos + SW'(sq);
                            r_step  <= r_step + 1'b1;
                            r_state <= S_FETCH;
                        end
                    end
                end
                S_CMP: begin
                    // data for index r_idx-1 is on the read registers
                    if (r_key_rd != r_pend_rd) begin
                        r_pos   <= r_pos + SW'(sq);
                        r_step  <= r_step + 1'b1;
                        r_idx   <= '0;
                        r_state <= S_FETCH;
                    end else if (r_idx == r_len)
                        finish(ST_FOUND, 6'(r_pos), r_type_rd);
                    else r_idx <= r_idx + 1'b1;
                end
                S_WRITE: begin
                    if (r_idx == r_len) begin
                        r_used[r_pos] <= 1'b1;
                        r_count <= r_count + 1'b1;
                        finish(ST_INSERTED, 6'(r_pos), 3'd0);
                    end else r_idx <= r_idx + 1'b1;
                end
                default: r_state <= S_HASH;
            endcase
        end
    end

    assign o_valid      = r_ovalid;
    assign o_status     = r_status;
    assign o_slot_index = r_slot;
    assign o_found_type = r_ftype;

    a_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state <= S_FETCH) else $error("bad state");
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_HASH) |-> !o_ready) else $error("ready while busy");
    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(TABLE_SLOTS)) else $error("count overflow");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> $stable(o_status)) else $error("result changed");
endmodule

[tb/sv/skht_checker.sv]
// Checker for string_key_hash_table_core: watches both channels, predicts results.
// Depends on skht_pkg.
module skht_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic       o_ready,
    input  logic [0:0] i_opcode,
    input  logic [7:0] i_key_byte,
    input  logic [0:0] i_last_byte,
    input  logic [2:0] i_var_type,
    input  logic       o_valid,
    input  logic       i_ready,
    input  logic [2:0] o_status,
    input  logic [5:0] o_slot_index,
    input  logic [2:0] o_found_type,
    output int         err_count,
    output int         pending_cnt
);
    timeunit 1ns;
    timeprecision 1ps;
    import skht_pkg::*;

    localparam int NSLOT = 64;
    localparam int MAXK  = 32;

    typedef struct packed {
        logic [2:0] status;
        logic [5:0] slot;
        logic [2:0] vtype;
    } t_lookup_res;

    logic        used [NSLOT];
    logic [7:0]  skey [NSLOT][MAXK];
    int          slen [NSLOT];
    logic [2:0]  styp [NSLOT];
    int          n_entries;
    logic [63:0] hash;
    logic [7:0]  kbuf [MAXK];
    int          klen;
    logic        too_long;
    t_lookup_res result_q[$];

    function automatic bit key_eq(int s);
        if (slen[s] != klen) return 0;
        for (int j = 0; j < klen; j++)
            if (skey[s][j] != kbuf[j]) return 0;
        return 1;
    endfunction

    function automatic t_lookup_res finish_key(logic [0:0] op, logic [2:0] vt);
        t_lookup_res r;
        int pos;
        r = '{ST_NOT_FOUND, 6'd0, 3'd0};
        pos = int'(hash % NSLOT);
        if (too_long) begin
            r.status = ST_TOO_LONG;
            return r;
        end
        if (op == OP_INSERT) begin
            r.status = ST_FULL;
            if (n_entries >= NSLOT) return r;
            for (int i = 1; i <= NSLOT; i++) begin
                if (!used[pos]) begin
                    used[pos] = 1;
                    for (int j = 0; j < klen; j++) skey[pos][j] = kbuf[j];
                    slen[pos] = klen;
                    styp[pos] = vt;
                    n_entries++;
                    r.status = ST_INSERTED;
                    r.slot = pos[5:0];
                    return r;
                end
                pos = (pos + i * i) % NSLOT;
            end
            return r;
        end
        for (int i = 1; i <= NSLOT; i++) begin
            if (!used[pos]) return r;
            if (key_eq(pos)) begin
                r = '{ST_FOUND, pos[5:0], styp[pos]};
                return r;
            end
            pos = (pos + i * i) % NSLOT;
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_lookup_res exp_r;
        if (!i_rst_n) begin
            foreach (used[s]) used[s] = 0;
            n_entries = 0;
            hash = HASH_SEED;
            klen = 0;
            too_long = 0;
            result_q.delete();
            err_count = 0;
        end else begin
            if (o_valid && i_ready) begin
                if (result_q.size() == 0) begin
                    $display("%0t: unexpected result status=%0d slot=%0d type=%0d",
                             $time, o_status, o_slot_index, o_found_type);
                    err_count++;
                end else begin
                    exp_r = result_q.pop_front();
                    if (o_status !== exp_r.status || o_slot_index !== exp_r.slot ||
                        o_found_type !== exp_r.vtype) begin
                        $display("%0t: mismatch exp status=%0d slot=%0d type=%0d, got %0d %0d %0d",
                                 $time, exp_r.status, exp_r.slot, exp_r.vtype,
                                 o_status, o_slot_index, o_found_type);
                        err_count++;
                    end
                end
            end
            if (i_valid && o_ready) begin
                hash = hash * 64'd33 + 64'(i_key_byte);
                if (klen < MAXK) begin
                    kbuf[klen] = i_key_byte;
                    klen++;
                end else begin
                    too_long = 1;
                end
                if (i_last_byte) begin
                    result_q.push_back(finish_key(i_opcode, i_var_type));
                    hash = HASH_SEED;
                    klen = 0;
                    too_long = 0;
                end
            end
        end
        pending_cnt = result_q.size();
    end
endmodule

[tb/sv/tb.sv]
// Testbench top for string_key_hash_table_core: stimulus, idling, verdict.
// Depends on skht_pkg, skht_checker and the RTL.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import skht_pkg::*;

    localparam int WDOG = 20000;

    logic       i_clk = 0;
    logic       i_rst_n = 0;
    logic       i_valid = 0;
    logic       o_ready;
    logic [0:0] i_opcode = 0;
    logic [7:0] i_key_byte = 0;
    logic [0:0] i_last_byte = 0;
    logic [2:0] i_var_type = 0;
    logic       o_valid;
    logic       i_ready = 0;
    logic [2:0] o_status;
    logic [5:0] o_slot_index;
    logic [2:0] o_found_type;
    int         err_count;
    int         pending_cnt;
    bit         quiet_tail = 0;
    bit         long_hold = 0;
    int         idle_cycles = 0;

    // Pool of keys so lookups hit stored entries.
    logic [7:0] pool_key [16][40];
    int         pool_len [16];

    always #2 i_clk = ~i_clk;

    string_key_hash_table_core dut (.*);

    skht_checker chk (.*);

    // Watchdog on cycles with no accepted item on either side.
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WDOG) begin
            $display("FAIL");
            $finish;
        end
    end

    // Receiver: random stall bursts, one long hold-off on request.
    initial begin
        int n;
        @(posedge i_clk);
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            if (long_hold) begin
                i_ready <= 0;
                repeat (200) @(posedge i_clk);
                long_hold = 0;
            end else if (!quiet_tail && $urandom_range(0, 3) == 0) begin
                i_ready <= 0;
                n = $urandom_range(1, 3);
                repeat (n) @(posedge i_clk);
            end else begin
                i_ready <= 1;
                @(posedge i_clk);
            end
        end
    end

    // Valid stays up between items; it drops only in an idle burst or a drain.
    task automatic send_byte(logic [0:0] op, logic [7:0] b, logic lastb, logic [2:0] vt);
        int n;
        if (!quiet_tail && $urandom_range(0, 4) == 0) begin
            i_valid <= 0;
            n = $urandom_range(1, 3);
            repeat (n) @(posedge i_clk);
        end
        i_valid <= 1;
        i_opcode <= op;
        i_key_byte <= b;
        i_last_byte <= lastb;
        i_var_type <= vt;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
    endtask

    // Key from the pool; other-byte opcode and type are noise.
    task automatic send_pool_key(int k, logic [0:0] op, logic [2:0] vt);
        for (int j = 0; j < pool_len[k]; j++)
            send_byte((j == pool_len[k] - 1) ? op : 1'($urandom), pool_key[k][j],
                      j == pool_len[k] - 1, (j == pool_len[k] - 1) ? vt : 3'($urandom));
    endtask

    task automatic drain();
        i_valid <= 0;
        @(posedge i_clk);
        while (pending_cnt != 0) @(posedge i_clk);
    endtask

    initial begin
        int k;
        int items;
        bit held;
        bit drained;
        for (int p = 0; p < 16; p++) begin
            pool_len[p] = (p < 12) ? $urandom_range(1, 6) : $urandom_range(1, 34);
            for (int j = 0; j < 40; j++) pool_key[p][j] = 8'($urandom);
        end
        pool_len[0] = 1; pool_key[0][0] = 8'h00;
        pool_len[1] = 1; pool_key[1][0] = 8'hff;
        pool_len[2] = 32;
        pool_len[3] = 33;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // Directed: empty lookup, inserts incl. extreme bytes/types, hits, overlong.
        send_pool_key(0, OP_LOOKUP, 0);
        send_pool_key(0, OP_INSERT, 0);
        send_pool_key(1, OP_INSERT, 7);
        send_pool_key(2, OP_INSERT, 5);
        send_pool_key(0, OP_INSERT, 6);
        send_pool_key(0, OP_LOOKUP, 0);
        send_pool_key(1, OP_LOOKUP, 0);
        send_pool_key(2, OP_LOOKUP, 0);
        send_pool_key(3, OP_INSERT, 3);
        send_pool_key(3, OP_LOOKUP, 3);
        send_pool_key(4, OP_LOOKUP, 2);
        drain();

        // Random: mostly pool keys, some random keys.
        items = 0;
        held = 0;
        drained = 0;
        while (items < 840) begin
            if (items > 700) quiet_tail = 1;
            if (items >= 300 && !held) begin
                long_hold = 1;
                held = 1;
            end
            if (items >= 500 && !drained) begin
                drain();
                drained = 1;
            end
            k = $urandom_range(0, 15);
            if ($urandom_range(0, 5) == 0) begin
                int len;
                len = $urandom_range(1, 8);
                for (int j = 0; j < len; j++)
                    send_byte(1'($urandom), 8'($urandom), j == len - 1, 3'($urandom));
                items += len;
            end else begin
                send_pool_key(k, 1'($urandom), 3'($urandom));
                items += pool_len[k];
            end
        end
        // Fill the table to reach the full case.
        for (int r = 0; r < 70; r++)
            send_byte(OP_INSERT, 8'($urandom), 1, 3'($urandom));
        send_pool_key(5, OP_LOOKUP, 0);
        drain();
        repeat (100) @(posedge i_clk);
        if (err_count == 0 && pending_cnt == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule
